// ----- hw/rtl/nmps_pkg.sv -----
// Shared types, register codes, queue sizes and grey-level helper for the median pixel select.
package nmps_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	// configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// queues
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int OCW       = $clog2(OUT_DEPTH + 1);
	localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

	// neighbourhood
	localparam int WIN_SIZE    = 9;
	localparam int NBR_CNT     = 8;
	localparam int MEDIAN_RANK = 3;
	// window slot of W, E, N, S, NW, SE, SW, NE
	localparam logic [3:0] NBR_IDX [NBR_CNT] = '{4'd3, 4'd5, 4'd1, 4'd7, 4'd0, 4'd8, 4'd6, 4'd2};

	// x / 3 == (x * 683) >> 11 for x <= 765
	localparam int GREY_RECIP = 683;
	localparam int GREY_SHIFT = 11;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_e;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		op_e        op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} out_beat_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic last;
	} cmd_ctl_t;

	function automatic logic [7:0] grey_of(input pixel_t p);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = {2'b00, p[23:16]} + {2'b00, p[15:8]} + {2'b00, p[7:0]};
		prod = 20'(sum) * 20'(GREY_RECIP);
		return prod[GREY_SHIFT+7:GREY_SHIFT];
	endfunction

endpackage

// ----- hw/rtl/nmps_fifo.sv -----
// Small register-based first-in first-out queue.
module nmps_fifo import nmps_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW  = $clog2(DEPTH),
	localparam int CNW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty,
	output logic [CNW-1:0]   count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]   count_q;
	logic             do_push, do_pop;

	assign full    = count_q == CNW'(DEPTH);
	assign empty   = count_q == '0;
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- hw/rtl/nmps_front.sv -----
// Front end: config registers, raster counters, beat classification into commands.
module nmps_front import nmps_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int CW = $clog2(MAX_WIDTH + 1),
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT + 1) + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	input  in_beat_t              pixel,
	output logic                  full,
	input  logic                  cmd_full,
	output logic                  cmd_push,
	output logic [AW-1:0]         cmd_col,
	output pixel_t                cmd_px,
	output cmd_ctl_t              cmd_ctl
);

	function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] lim);
		if (v == 32'd0) begin
			return 32'd1;
		end
		if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

	logic [CW-1:0] w_q, in_col_q, out_col_q;
	logic [RW-1:0] h_q, in_row_q, out_row_q;
	logic [CW-1:0] in_col_inc, out_col_inc;
	logic [RW-1:0] in_row_inc, out_row_inc;
	logic          accept, drain, tick, emit, last, border;
	logic [31:0]   cfg_ext;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign drain    = in_row_q >= h_q;
	// flush before the frame is complete is swallowed
	assign tick     = accept && (drain || pixel.op != OP_FLUSH);

	assign in_col_inc  = in_col_q + CW'(1);
	assign in_row_inc  = in_row_q + RW'(1);
	assign out_col_inc = out_col_q + CW'(1);
	assign out_row_inc = out_row_q + RW'(1);

	assign emit   = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
	assign last   = (out_row_inc >= h_q) && (out_col_inc >= w_q);
	assign border = !(out_row_q != '0 && out_row_inc < h_q &&
	                  out_col_q != '0 && out_col_inc < w_q);
	assign cfg_ext = {{(32 - CFG_DATA_W){1'b0}}, cfg_wdata};

	assign cmd_push = tick;
	assign cmd_col  = in_col_q[AW-1:0];
	assign cmd_px   = drain ? '0 : {pixel.red_in, pixel.green_in, pixel.blue_in};
	assign cmd_ctl  = '{emit: emit, border: border, last: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= CW'(clamp_dim(32'(RESET_WIDTH), 32'(MAX_WIDTH)));
			h_q       <= RW'(clamp_dim(32'(RESET_HEIGHT), 32'(MAX_HEIGHT)));
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH:  w_q <= CW'(clamp_dim(cfg_ext, 32'(MAX_WIDTH)));
				REG_IMAGE_HEIGHT: h_q <= RW'(clamp_dim(cfg_ext, 32'(MAX_HEIGHT)));
				default: ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (tick) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_inc >= w_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_inc;
				end else begin
					in_col_q <= in_col_inc;
				end
				if (emit) begin
					if (out_col_inc >= w_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc;
					end else begin
						out_col_q <= out_col_inc;
					end
				end
			end
		end
	end

endmodule

// ----- hw/rtl/nmps_back.sv -----
// Back end: line store, 3x3 window, grey levels and rank select of the neighbour pixel.
module nmps_back import nmps_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  logic [AW-1:0]  cmd_col,
	input  pixel_t         cmd_px,
	input  cmd_ctl_t       cmd_ctl,
	output logic           cmd_pop,
	input  logic [OCW-1:0] res_count,
	output logic           res_push,
	output out_beat_t      res_beat
);

	// one entry per column: {upper row, lower row}
	logic [47:0] line_mem [MAX_WIDTH];
	logic [47:0] rd_raw_s1, byp_data_s1, rd_s1, wr_data;
	logic        byp_s1;

	logic          v_s1, v_s2, v_s3;
	logic [AW-1:0] col_s1;
	pixel_t        px_s1;
	cmd_ctl_t      ctl_s1;
	logic          border_s2, last_s2;
	logic          border_s3, last_s3;
	pixel_t        win_q [WIN_SIZE];
	pixel_t        nb [NBR_CNT];
	logic [7:0]    grey [NBR_CNT];
	pixel_t        nb_s3 [NBR_CNT];
	logic [7:0]    g_s3 [NBR_CNT];
	pixel_t        ctr_s3;
	logic [3:0]    less_cnt [NBR_CNT];
	logic [3:0]    le_cnt [NBR_CNT];
	logic [2:0]    sel;
	pixel_t        res;
	logic [OCW:0]  busy;

	// credit: every popped command may land in the result queue
	assign busy = {1'b0, res_count} + (OCW+1)'(v_s1) + (OCW+1)'(v_s2) + (OCW+1)'(v_s3);
	assign cmd_pop = !cmd_empty && (busy < (OCW+1)'(OUT_DEPTH));

	// line store: read at pop, written back in the following cycle
	assign rd_s1   = byp_s1 ? byp_data_s1 : rd_raw_s1;
	assign wr_data = {rd_s1[23:0], px_s1};

	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_mem[col_s1] <= wr_data;
		end
		if (cmd_pop) begin
			rd_raw_s1 <= line_mem[cmd_col];
		end
	end

	// same column back to back (one-pixel rows) takes the write data
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			byp_s1      <= v_s1 && (col_s1 == cmd_col);
			byp_data_s1 <= wr_data;
			col_s1      <= cmd_col;
			px_s1       <= cmd_px;
			ctl_s1      <= cmd_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k < WIN_SIZE; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			v_s1 <= cmd_pop;
			v_s2 <= v_s1 && ctl_s1.emit;
			v_s3 <= v_s2;
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= rd_s1[47:24];
				win_q[5] <= rd_s1[23:0];
				win_q[8] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		border_s2 <= ctl_s1.border;
		last_s2   <= ctl_s1.last;
	end

	// s2: neighbour grey levels
	always_comb begin
		for (int k = 0; k < NBR_CNT; k++) begin
			nb[k]   = win_q[NBR_IDX[k]];
			grey[k] = grey_of(nb[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NBR_CNT; k++) begin
			nb_s3[k] <= nb[k];
			g_s3[k]  <= grey[k];
		end
		ctr_s3    <= win_q[4];
		border_s3 <= border_s2;
		last_s3   <= last_s2;
	end

	// s3: neighbour i holds the 4th smallest grey when less(i) <= 3 < lessequal(i);
	// the last such neighbour wins
	always_comb begin
		sel = '0;
		for (int i = 0; i < NBR_CNT; i++) begin
			less_cnt[i] = '0;
			le_cnt[i]   = '0;
			for (int j = 0; j < NBR_CNT; j++) begin
				less_cnt[i] = less_cnt[i] + 4'(g_s3[j] < g_s3[i]);
				le_cnt[i]   = le_cnt[i] + 4'(g_s3[j] <= g_s3[i]);
			end
			if (less_cnt[i] <= 4'(MEDIAN_RANK) && le_cnt[i] > 4'(MEDIAN_RANK)) begin
				sel = 3'(i);
			end
		end
	end

	assign res      = border_s3 ? ctr_s3 : nb_s3[sel];
	assign res_push = v_s3;
	assign res_beat = '{red_out: res[23:16], green_out: res[15:8], blue_out: res[7:0],
	                    frame_end: last_s3};

endmodule

// ----- hw/rtl/neighbour_median_pixel_select.sv -----
// Top level of the 3x3 neighbour median pixel select filter.
//
// Usage: RGB pixels enter in raster order on a queue-style port (push/full,
// payload pixel). op = OP_FLUSH beats drain the delayed results at frame end;
// a flush before the last pixel of a frame is taken and dropped.
// Results leave on a queue-style port (empty/pop, payload result): one
// filtered pixel per frame pixel, frame_end set on the last one. Border
// pixels pass through; interior pixels take the neighbour whose grey level
// is the 4th smallest of the eight.
// Output pixel p is produced by the tick at linear input position p+w+1, so
// a frame of w*h pixels needs w+1 trailing ticks (flush beats or pixels of
// no frame).
// A beat's result passes the command queue, back end stages s1, s2, s3 and the result queue.
// Throughput: one beat per cycle while full is low; a new beat is taken while results wait.
// Receiver stall: the 8-entry result queue fills, the back end stops taking
// commands, the 4-entry command queue fills and full rises.
// Config (cfg_we/cfg_addr/cfg_wdata) is to be written by the user only while
// idle; the block does not enforce it. A write restarts the frame. Reset: width
// 640, height 480, counters and queues cleared; line store garbage never reaches a result.
module neighbour_median_pixel_select import nmps_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  in_beat_t              pixel,
	output logic                  empty,
	input  logic                  pop,
	output out_beat_t             result
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int CMD_W = AW + $bits(pixel_t) + $bits(cmd_ctl_t);

	// front -> command queue
	logic              cmd_push, cmd_full;
	logic [AW-1:0]     fr_col;
	pixel_t            fr_px;
	cmd_ctl_t          fr_ctl;
	// command queue -> back
	logic              cmd_pop, cmd_empty;
	logic [CMD_W-1:0]  cmd_rdata;
	logic [CMD_CW-1:0] cmd_count;
	logic [AW-1:0]     bk_col;
	pixel_t            bk_px;
	cmd_ctl_t          bk_ctl;
	// back -> result queue
	logic              res_push, res_full;
	out_beat_t         res_beat;
	logic [OCW-1:0]    res_count;
	logic [$bits(out_beat_t)-1:0] res_rdata;

	nmps_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd_col   (fr_col),
		.cmd_px    (fr_px),
		.cmd_ctl   (fr_ctl)
	);

	nmps_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  ({fr_col, fr_px, fr_ctl}),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.full   (cmd_full),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	assign {bk_col, bk_px, bk_ctl} = cmd_rdata;

	nmps_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_col   (bk_col),
		.cmd_px    (bk_px),
		.cmd_ctl   (bk_ctl),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_beat  (res_beat)
	);

	nmps_fifo #(
		.WIDTH ($bits(out_beat_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_beat),
		.pop    (pop),
		.rdata  (res_rdata),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

	assign result = out_beat_t'(res_rdata);

	// credit scheme must never overrun the result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full result queue");

	// back end pipeline is a fixed three stages from pop to result
	a_res_timing: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> $past(cmd_pop, 3))
		else $error("result without command popped three cycles earlier");

	// back end only pops commands that exist
	a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_count != '0)
		else $error("command popped from empty queue");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for neighbour_median_pixel_select: raster frames in, filtered pixels out.
`timescale 1ns / 100ps

module tb_top;
	import nmps_pkg::*;

	// Our own copies of the limits and reset sizes, so a wrong package value is not trusted.
	localparam int LINE_MAX       = 2048;
	localparam int ROWS_MAX       = 2048;
	localparam int DEFAULT_WIDTH  = 640;
	localparam int DEFAULT_HEIGHT = 480;
	// Spare time after the last result, for any beat still in flight that makes no result.
	localparam int SETTLE_CYCLES  = 8;
	localparam int STALL_LIMIT    = 4000;
	localparam int RANDOM_BEATS   = 330;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic      push      = 1'b0;
	logic      full;
	in_beat_t  pixel_beat = '0;
	logic      empty;
	logic      pop       = 1'b0;
	out_beat_t result_beat;

	neighbour_median_pixel_select i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.full     (full),
		.pixel    (pixel_beat),
		.empty    (empty),
		.pop      (pop),
		.result   (result_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Filter predictor: mirror of the block's line stores, window and
	// raster counters. Updated once per accepted input beat.
	// ------------------------------------------------------------------
	logic [11:0] width_reg  = 12'(DEFAULT_WIDTH);
	logic [11:0] height_reg = 12'(DEFAULT_HEIGHT);
	pixel_t      row_two_up [LINE_MAX];
	pixel_t      row_one_up [LINE_MAX];
	pixel_t      win [9];          // slot = row*3 + col, row 0 is north, col 0 is west
	int unsigned in_col_pos, in_row_pos, out_col_pos, out_row_pos;

	out_beat_t   expected_pixels [$];
	in_beat_t    pending_beats [$];
	int          beats_queued = 0;
	int          beats_taken  = 0;
	int          random_beats = 0;
	int          mismatches   = 0;
	int          stall_cycles = 0;
	int          send_idle_pct = 11;
	int          recv_idle_pct = 49;

	// Register value as the block uses it: zero means one, oversize clips.
	function automatic int unsigned eff_dim(input logic [11:0] v, input int unsigned lim);
		if (v == 12'd0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return v;
	endfunction

	function automatic void restart_frame_model();
		int i;
		for (i = 0; i < 9; i++)
			win[i] = '0;
		in_col_pos  = 0;
		in_row_pos  = 0;
		out_col_pos = 0;
		out_row_pos = 0;
	endfunction

	function automatic logic [7:0] grey_level(input pixel_t p);
		return 8'((32'(p[23:16]) + 32'(p[15:8]) + 32'(p[7:0])) / 3);
	endfunction

	// Window slot of neighbour n, in the order W, E, N, S, NW, SE, SW, NE.
	function automatic int nbr_slot(input int n);
		case (n)
			0: return 3;
			1: return 5;
			2: return 1;
			3: return 7;
			4: return 0;
			5: return 8;
			6: return 6;
			default: return 2;
		endcase
	endfunction

	// Fourth smallest grey of the eight neighbours; on a tie the last
	// neighbour in the fixed order wins.
	function automatic pixel_t median_neighbour();
		logic [7:0] g [8];
		logic [7:0] s [8];
		logic [7:0] t;
		int i, j, sel;
		for (i = 0; i < 8; i++) begin
			g[i] = grey_level(win[nbr_slot(i)]);
			s[i] = g[i];
		end
		for (i = 0; i < 8; i++)
			for (j = 0; j < 7 - i; j++)
				if (s[j] > s[j+1]) begin
					t      = s[j];
					s[j]   = s[j+1];
					s[j+1] = t;
				end
		sel = 0;
		for (i = 0; i < 8; i++)
			if (g[i] == s[MEDIAN_RANK])
				sel = i;
		return win[nbr_slot(sel)];
	endfunction

	function automatic void run_filter_model(input in_beat_t b);
		int unsigned w, h, col;
		int          r;
		pixel_t      px, up, lo, res;
		logic        drain, emit, last;
		out_beat_t   e;
		w     = eff_dim(width_reg, LINE_MAX);
		h     = eff_dim(height_reg, ROWS_MAX);
		drain = (in_row_pos >= h);
		// flush while the frame still wants pixels: dropped without a trace
		if (!drain && b.op == OP_FLUSH)
			return;
		// once every pixel is in, any beat is a drain tick carrying zero
		px  = drain ? '0 : {b.red_in, b.green_in, b.blue_in};
		col = (in_col_pos >= LINE_MAX) ? LINE_MAX - 1 : in_col_pos;
		up  = row_two_up[col];
		lo  = row_one_up[col];
		row_two_up[col] = lo;
		row_one_up[col] = px;
		for (r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = up;
		win[5] = lo;
		win[8] = px;
		emit = (in_row_pos >= 2) || (in_row_pos == 1 && in_col_pos >= 1);
		in_col_pos++;
		if (in_col_pos >= w) begin
			in_col_pos = 0;
			in_row_pos++;
		end
		if (!emit)
			return;
		// border pixels pass straight through
		if (out_row_pos >= 1 && out_row_pos + 1 < h && out_col_pos >= 1 && out_col_pos + 1 < w)
			res = median_neighbour();
		else
			res = win[4];
		last        = (out_row_pos + 1 >= h) && (out_col_pos + 1 >= w);
		e.red_out   = res[23:16];
		e.green_out = res[15:8];
		e.blue_out  = res[7:0];
		e.frame_end = last;
		expected_pixels.push_back(e);
		if (last) begin
			restart_frame_model();
		end else begin
			out_col_pos++;
			if (out_col_pos >= w) begin
				out_col_pos = 0;
				out_row_pos++;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents pending beats, holds a beat while full is high,
	// and feeds every accepted beat to the predictor.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				run_filter_model(pixel_beat);
				beats_taken++;
			end
			if (!push || !full) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push       <= 1'b1;
					pixel_beat <= pending_beats.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	function automatic void check_pixel(input out_beat_t got);
		out_beat_t want;
		if (expected_pixels.size() == 0) begin
			if (mismatches < 10)
				$display("[%0t] unexpected result %h %h %h fe=%b", $realtime,
					got.red_out, got.green_out, got.blue_out, got.frame_end);
			mismatches++;
			return;
		end
		want = expected_pixels.pop_front();
		if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
				got.blue_out !== want.blue_out || got.frame_end !== want.frame_end) begin
			if (mismatches < 10)
				$display("[%0t] mismatch: expected %h %h %h fe=%b, got %h %h %h fe=%b",
					$realtime, want.red_out, want.green_out, want.blue_out, want.frame_end,
					got.red_out, got.green_out, got.blue_out, got.frame_end);
			mismatches++;
		end
	endfunction

	// Monitor: random pop, compare every popped beat with the oldest expectation.
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && pop && !empty)
			check_pixel(result_beat);
	end

	// Watchdog: too long without any beat moving on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** neighbour_median_pixel_select: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_beat(input op_e op, input pixel_t c);
		in_beat_t b;
		b.op       = op;
		b.red_in   = c[23:16];
		b.green_in = c[15:8];
		b.blue_in  = c[7:0];
		pending_beats.push_back(b);
		beats_queued++;
	endtask

	// Block is idle once everything sent is taken and every result is back;
	// then give any result-less beat time to leave the pipeline.
	task automatic wait_idle();
		while (beats_queued != beats_taken || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [11:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = val;
		else
			height_reg = val;
		// any register write abandons the frame in flight
		restart_frame_model();
	endtask

	task automatic program_dims(input bit do_w, input logic [11:0] w,
			input bit do_h, input logic [11:0] h);
		wait_idle();
		if (do_w)
			write_reg(REG_IMAGE_WIDTH, w);
		if (do_h)
			write_reg(REG_IMAGE_HEIGHT, h);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly small frames; zero and one hit the clamp and the degenerate shapes.
	task automatic reconfig_random();
		logic [11:0] w, h;
		bit          do_w, do_h;
		case ($urandom_range(9))
			0: w = 12'd0;
			1: w = 12'd1;
			default: w = 12'($urandom_range(7, 2));
		endcase
		case ($urandom_range(9))
			0: h = 12'd0;
			1: h = 12'd1;
			default: h = 12'($urandom_range(5, 2));
		endcase
		do_w = $urandom_range(1);
		do_h = !do_w || $urandom_range(1);
		program_dims(do_w, w, do_h, h);
	endtask

	// Colour styles: full random, saturated channels, a tight band that
	// makes grey ties common, and near-grey pixels.
	function automatic pixel_t pick_colour(input int style);
		logic [7:0] v;
		case (style)
			0: return 24'($urandom);
			1: return {($urandom_range(1) ? 8'hFF : 8'h00), ($urandom_range(1) ? 8'hFF : 8'h00),
					($urandom_range(1) ? 8'hFF : 8'h00)};
			2: return {8'($urandom_range(42, 40)), 8'($urandom_range(42, 40)),
					8'($urandom_range(42, 40))};
			default: begin
				v = 8'($urandom_range(255));
				return {v, v ^ 8'($urandom_range(3)), v};
			end
		endcase
	endfunction

	// First n pixels of a frame at the current sizes; the next register
	// write cuts the frame off.
	task automatic queue_partial(input int style, input int unsigned n);
		int unsigned k;
		for (k = 0; k < n; k++)
			queue_beat(OP_PIXEL, pick_colour(style));
	endtask

	// One frame at the current sizes: w*h pixels with stray flushes, then
	// w+1 trailing ticks. An abandoned frame stops at a random beat.
	task automatic queue_frame(input int style, input bit abandon);
		int unsigned w, h, total, stop, k;
		w     = eff_dim(width_reg, LINE_MAX);
		h     = eff_dim(height_reg, ROWS_MAX);
		total = w * h + w + 1;
		stop  = abandon ? $urandom_range(total - 1, 0) : total;
		for (k = 0; k < stop; k++) begin
			if (k < w * h) begin
				if ($urandom_range(15) == 0)
					queue_beat(OP_FLUSH, 24'($urandom));
				queue_beat(OP_PIXEL, pick_colour(style));
			end else begin
				// a pixel here is only a drain tick, its colour is dropped
				queue_beat($urandom_range(1) ? OP_FLUSH : OP_PIXEL, 24'($urandom));
			end
		end
		if (!abandon && $urandom_range(3) == 0)
			queue_beat(OP_FLUSH, 24'($urandom));
		random_beats += stop;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		pixel_t dir_px [9];
		int     k, pace_step;
		bit     abandoned;

		for (k = 0; k < LINE_MAX; k++) begin
			row_two_up[k] = '0;
			row_one_up[k] = '0;
		end
		restart_frame_model();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes (640 wide): a short partial frame, still inside the first
		// rows, abandoned by the first register write.
		for (k = 0; k < 40; k++)
			queue_beat(OP_PIXEL, 24'($urandom));

		// 3x3 with one interior pixel. Neighbour greys 0,2,85,85,85,127,128,255:
		// three-way tie at the fourth rank, channel extremes on the border.
		dir_px = '{24'h000000, 24'hFFFFFF, 24'h010203,
			24'hFF0000, 24'hAA55AA, 24'h00FF00,
			24'h0000FF, 24'h808080, 24'h7F7F7F};
		program_dims(1'b1, 12'd3, 1'b1, 12'd3);
		for (k = 0; k < 9; k++) begin
			queue_beat(OP_PIXEL, dir_px[k]);
			if (k == 4)
				queue_beat(OP_FLUSH, 24'hFFFFFF);   // mid-frame flush, ignored
		end
		queue_beat(OP_FLUSH, '0);
		queue_beat(OP_PIXEL, 24'hFFFFFF);           // pixel past frame end acts as a tick
		queue_beat(OP_FLUSH, '0);
		queue_beat(OP_FLUSH, '0);
		queue_beat(OP_FLUSH, 24'h5A5A5A);           // after frame end: ignored again

		// One-row frame: the first drain tick has nothing due.
		program_dims(1'b1, 12'd2, 1'b1, 12'd1);
		queue_beat(OP_PIXEL, 24'h123456);
		queue_beat(OP_PIXEL, 24'hFEDCBA);
		queue_beat(OP_FLUSH, '0);
		queue_beat(OP_PIXEL, 24'h000000);
		queue_beat(OP_FLUSH, '0);

		// Random frames in three pacing phases.
		pace_step = 0;
		abandoned = 1'b0;
		while (random_beats < RANDOM_BEATS) begin
			if (pace_step == 0 && random_beats >= RANDOM_BEATS / 3) begin
				wait_idle();
				send_idle_pct = 49;
				recv_idle_pct = 11;
				pace_step     = 1;
			end else if (pace_step == 1 && random_beats >= 2 * RANDOM_BEATS / 3) begin
				wait_idle();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				pace_step     = 2;
			end
			// an abandoned frame must be cut off by a register write
			if (abandoned || $urandom_range(2) != 0)
				reconfig_random();
			abandoned = ($urandom_range(7) == 0);
			queue_frame($urandom_range(3), abandoned);
		end

		// Size extremes, no idling: oversize sizes clip, shown on short partial
		// frames that the next register write cuts off; zero sizes mean one.
		program_dims(1'b1, 12'd4095, 1'b1, 12'd1);
		queue_partial(0, 24);
		program_dims(1'b1, 12'd1, 1'b1, 12'd4095);
		queue_partial(3, 24);
		program_dims(1'b1, 12'd2048, 1'b1, 12'd3);
		queue_partial(2, 24);
		program_dims(1'b1, 12'd0, 1'b1, 12'd0);
		queue_frame(0, 1'b0);
		program_dims(1'b0, 12'd0, 1'b1, 12'd5);
		queue_frame(1, 1'b0);

		wait_idle();
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("** neighbour_median_pixel_select: PASSED **");
		else
			$display("** neighbour_median_pixel_select: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/nmps_pkg.sv
hw/rtl/nmps_fifo.sv
hw/rtl/nmps_front.sv
hw/rtl/nmps_back.sv
hw/rtl/neighbour_median_pixel_select.sv
test/tb_top.sv
